// File: src/cfe_pkg.sv
`timescale 1ns / 1ps
package cfe_pkg;

  localparam logic [1:0]  CFG_GROUP_MODE  = 2'd0;
  localparam logic [1:0]  CFG_CELL_COUNT  = 2'd1;
  localparam logic [1:0]  CFG_INNER_COUNT = 2'd2;

  localparam logic [6:0]  CELL_COUNT_RST  = 7'd48;
  localparam logic [6:0]  INNER_COUNT_RST = 7'd32;
  localparam logic [15:0] CELL_MAX        = 16'hFFFF;
  localparam logic [21:0] SUM_MAX         = 22'h3FFFFF;
  localparam logic [15:0] FLAT_MAX        = 16'hFFFF;
  localparam logic [4:0]  DIV_LAST        = 5'd31;
  localparam logic [4:0]  ROOT_LAST       = 5'd15;
  localparam logic [31:0] ROOT_BIT_INIT   = 32'h4000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HIT,
    ST_SUM,
    ST_DRAIN,
    ST_MUL1,
    ST_MUL2,
    ST_CHECK,
    ST_DIV,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_LOAD,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic hit_load;
    logic hit_write;
    logic sum_start;
    logic sum_step;
    logic mul1;
    logic mul2;
    logic clear;
    logic div_start;
    logic div_step;
    logic root_start;
    logic root_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit_last;
    logic sum_last;
    logic pipe_empty;
    logic s_zero;
    logic d_ge_m;
    logic div_last;
    logic root_last;
  } sts_t;

endpackage

// File: src/cell_flatness_estimator_top.sv
`timescale 1ns / 1ps
// Each hit: store read issued with the accept, then a write; one at a time.
// Last hit: write, a pass over the N cells of the store, drain, products
// and check, 32-step divide, 16-step square root with set-up and load; a
// zero sum or flatness >= 1 skips the divide and root.
// Output word is held until taken; no new hit is accepted meanwhile.
// Reset (async, low) restores register defaults and empties the cell store.
module cell_flatness_estimator_top #(
  parameter int MAX_CELLS = 64,
  parameter int AMP_BITS  = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // channel[7:0], amplitude[19:8], zero pad
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // flatness[15:0], total_sum[37:16], zero pad
  output logic        m_axis_tuser,  // valid_res
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cfe_pkg::cmd_t cmd;
  cfe_pkg::sts_t sts;
  logic [15:0]   flatness;
  logic [21:0]   total_sum;

  assign cfg_ready_o = 1'b1;

  cfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfe_dp #(
    .MAX_CELLS (MAX_CELLS),
    .AMP_BITS  (AMP_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .channel_i   (s_axis_tdata[7:0]),
    .amplitude_i (s_axis_tdata[19:8]),
    .last_hit_i  (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .flatness_o  (flatness),
    .total_sum_o (total_sum),
    .valid_res_o (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, total_sum, flatness};

endmodule

// File: src/cfe_ram.sv
`timescale 1ns / 1ps
module cfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/cfe_ctrl.sv
`timescale 1ns / 1ps
module cfe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  cfe_pkg::sts_t sts_i,
  output cfe_pkg::cmd_t cmd_o
);

  cfe_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfe_pkg::ST_IDLE:      if (in_valid_i) state_d = cfe_pkg::ST_HIT;
      cfe_pkg::ST_HIT:       state_d = sts_i.hit_last ? cfe_pkg::ST_SUM : cfe_pkg::ST_IDLE;
      cfe_pkg::ST_SUM:       if (sts_i.sum_last) state_d = cfe_pkg::ST_DRAIN;
      cfe_pkg::ST_DRAIN:     if (sts_i.pipe_empty) state_d = cfe_pkg::ST_MUL1;
      cfe_pkg::ST_MUL1:      state_d = cfe_pkg::ST_MUL2;
      cfe_pkg::ST_MUL2:      state_d = cfe_pkg::ST_CHECK;
      cfe_pkg::ST_CHECK: begin
        state_d = (sts_i.s_zero || sts_i.d_ge_m) ? cfe_pkg::ST_OUT : cfe_pkg::ST_DIV;
      end
      cfe_pkg::ST_DIV:       if (sts_i.div_last) state_d = cfe_pkg::ST_ROOT_INIT;
      cfe_pkg::ST_ROOT_INIT: state_d = cfe_pkg::ST_ROOT;
      cfe_pkg::ST_ROOT:      if (sts_i.root_last) state_d = cfe_pkg::ST_LOAD;
      cfe_pkg::ST_LOAD:      state_d = cfe_pkg::ST_OUT;
      cfe_pkg::ST_OUT:       if (out_ready_i) state_d = cfe_pkg::ST_IDLE;
      default:               state_d = cfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      cfe_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.hit_load  = in_valid_i;
      end
      cfe_pkg::ST_HIT: begin
        cmd_o.hit_write = 1'b1;
        cmd_o.sum_start = sts_i.hit_last;
      end
      cfe_pkg::ST_SUM:       cmd_o.sum_step = 1'b1;
      cfe_pkg::ST_DRAIN:     ;
      cfe_pkg::ST_MUL1:      cmd_o.mul1 = 1'b1;
      cfe_pkg::ST_MUL2:      cmd_o.mul2 = 1'b1;
      cfe_pkg::ST_CHECK: begin
        cmd_o.clear     = 1'b1;
        cmd_o.out_load  = sts_i.s_zero || sts_i.d_ge_m;
        cmd_o.div_start = !(sts_i.s_zero || sts_i.d_ge_m);
      end
      cfe_pkg::ST_DIV:       cmd_o.div_step = 1'b1;
      cfe_pkg::ST_ROOT_INIT: cmd_o.root_start = 1'b1;
      cfe_pkg::ST_ROOT:      cmd_o.root_step = 1'b1;
      cfe_pkg::ST_LOAD:      cmd_o.out_load = 1'b1;
      cfe_pkg::ST_OUT:       out_valid_o = 1'b1;
      default:               ;
    endcase
  end

endmodule

// File: src/cfe_dp.sv
`timescale 1ns / 1ps
module cfe_dp #(
  parameter int MAX_CELLS = 64,
  parameter int AMP_BITS  = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  input  logic [7:0]    channel_i,
  input  logic [11:0]   amplitude_i,
  input  logic          last_hit_i,
  input  cfe_pkg::cmd_t cmd_i,
  output cfe_pkg::sts_t sts_o,
  output logic [15:0]   flatness_o,
  output logic [21:0]   total_sum_o,
  output logic          valid_res_o
);

  localparam int IDX_W = $clog2(MAX_CELLS);
  localparam int CNT_W = $clog2(MAX_CELLS + 1);
  localparam int S_W   = 16 + CNT_W;
  localparam int Q_W   = 32 + CNT_W;
  localparam int NQ_W  = CNT_W + Q_W;
  localparam int M_W   = CNT_W + 2 * S_W;
  localparam int R_W   = M_W + 1;
  localparam logic [11:0] AMP_MASK =
    (AMP_BITS >= 12) ? 12'hFFF : 12'((32'd1 << AMP_BITS) - 32'd1);

  logic                 group_mode_q;
  logic [6:0]           cell_count_q, inner_count_q;
  logic [CNT_W-1:0]     n_c;
  logic [7:0]           ch_q;
  logic [11:0]          amp_q;
  logic                 last_q;
  logic [IDX_W-1:0]     raddr, rd_addr_q, waddr;
  logic [15:0]          rdata, rd_cell, wdata;
  logic                 we;
  logic [7:0]           sec;
  logic [16:0]          amp2, dir_val, grp_val;
  logic [MAX_CELLS-1:0] valid_q;
  logic [CNT_W-1:0]     sum_cnt_q;
  logic                 rd_vld_q, sq_vld_q;
  logic [S_W-1:0]       s_q;
  logic [31:0]          sq_q;
  logic [Q_W-1:0]       q_q;
  logic [NQ_W-1:0]      nq_q, ss_q, d_q;
  logic [M_W-1:0]       m_q;
  logic [R_W-1:0]       rem_q, rem_t;
  logic [31:0]          quo_q;
  logic [31:0]          num_q, res_q, bit_q, res_b;
  logic [4:0]           step_q;
  logic                 d_ge_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_mode_q  <= 1'b0;
      cell_count_q  <= cfe_pkg::CELL_COUNT_RST;
      inner_count_q <= cfe_pkg::INNER_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cfe_pkg::CFG_GROUP_MODE:  group_mode_q  <= cfg_data_i[0];
        cfe_pkg::CFG_CELL_COUNT:  cell_count_q  <= cfg_data_i[6:0];
        cfe_pkg::CFG_INNER_COUNT: inner_count_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cell_count_q == 7'd0) begin
      n_c = CNT_W'(1);
    end else if (32'(cell_count_q) > MAX_CELLS) begin
      n_c = CNT_W'(MAX_CELLS);
    end else begin
      n_c = CNT_W'(cell_count_q);
    end
  end

  // hit capture, read issued with the accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_load) begin
      ch_q   <= channel_i;
      amp_q  <= amplitude_i & AMP_MASK;
      last_q <= last_hit_i;
    end
  end

  assign raddr = cmd_i.sum_step ? sum_cnt_q[IDX_W-1:0] : IDX_W'(channel_i >> 2);

  always_ff @(posedge clk_i) begin
    rd_addr_q <= raddr;
  end

  assign rd_cell = valid_q[rd_addr_q] ? rdata : 16'd0;
  assign sec     = ch_q >> 2;
  assign amp2    = {4'd0, amp_q, 1'b0};
  assign dir_val = (32'(ch_q) < 32'(inner_count_q)) ? amp2 : {5'd0, amp_q};
  assign grp_val = {1'b0, rd_cell} + amp2;

  always_comb begin
    if (group_mode_q) begin
      we    = cmd_i.hit_write && (32'(sec) < 32'(n_c)) && (32'(sec) < MAX_CELLS);
      waddr = IDX_W'(sec);
      wdata = grp_val[16] ? cfe_pkg::CELL_MAX : grp_val[15:0];
    end else begin
      we    = cmd_i.hit_write && (32'(ch_q) < MAX_CELLS);
      waddr = IDX_W'(ch_q);
      wdata = dir_val[16] ? cfe_pkg::CELL_MAX : dir_val[15:0];
    end
  end

  cfe_ram #(
    .WIDTH (16),
    .DEPTH (MAX_CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  // end-of-event pass: read, square, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      sq_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.sum_step;
      sq_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_start) begin
      sum_cnt_q <= '0;
    end else if (cmd_i.sum_step) begin
      sum_cnt_q <= sum_cnt_q + CNT_W'(1);
    end
    if (cmd_i.sum_start) begin
      s_q <= '0;
    end else if (rd_vld_q) begin
      s_q <= s_q + S_W'(rd_cell);
    end
    sq_q <= rd_cell * rd_cell;
    if (cmd_i.sum_start) begin
      q_q <= '0;
    end else if (sq_vld_q) begin
      q_q <= q_q + Q_W'(sq_q);
    end
    if (cmd_i.mul1) begin
      nq_q <= NQ_W'(n_c) * NQ_W'(q_q);
      ss_q <= NQ_W'(s_q) * NQ_W'(s_q);
    end
    if (cmd_i.mul2) begin
      d_q <= nq_q - ss_q;
      m_q <= M_W'(n_c) * M_W'(ss_q);
    end
  end

  assign d_ge_m = M_W'(d_q) >= m_q;
  assign rem_t  = {rem_q[R_W-2:0], 1'b0};
  assign res_b  = res_q + bit_q;

  // restoring divide of d*2^32 by m, then bitwise integer root
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start || cmd_i.root_start) begin
      step_q <= '0;
    end else if (cmd_i.div_step || cmd_i.root_step) begin
      step_q <= step_q + 5'd1;
    end
    if (cmd_i.div_start) begin
      rem_q <= R_W'(d_q);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_t >= {1'b0, m_q}) begin
        rem_q <= rem_t - {1'b0, m_q};
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_t;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.root_start) begin
      num_q <= quo_q;
      res_q <= '0;
      bit_q <= cfe_pkg::ROOT_BIT_INIT;
    end else if (cmd_i.root_step) begin
      if (num_q >= res_b) begin
        num_q <= num_q - res_b;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.out_load) begin
      if (s_q == '0) begin
        flatness_o <= '0;
      end else if (d_ge_m) begin
        flatness_o <= cfe_pkg::FLAT_MAX;
      end else begin
        flatness_o <= res_q[15:0];
      end
      total_sum_o <= (32'(s_q) > 32'(cfe_pkg::SUM_MAX)) ? cfe_pkg::SUM_MAX : 22'(s_q);
      valid_res_o <= s_q != '0;
    end
  end

  assign sts_o.hit_last   = last_q;
  assign sts_o.sum_last   = sum_cnt_q == (n_c - CNT_W'(1));
  assign sts_o.pipe_empty = !rd_vld_q && !sq_vld_q;
  assign sts_o.s_zero     = s_q == '0;
  assign sts_o.d_ge_m     = d_ge_m;
  assign sts_o.div_last   = step_q == cfe_pkg::DIV_LAST;
  assign sts_o.root_last  = step_q == cfe_pkg::ROOT_LAST;

endmodule

// File: src/cfe_checker.sv
`timescale 1ns / 1ps
module cfe_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_no_hit_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("hit accepted while result pending");

  a_no_result_mid_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> !m_axis_tvalid)
    else $error("result after a non-final hit");

  a_empty_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 40'd0))
    else $error("empty event result not zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result word changed");

endmodule

bind cell_flatness_estimator_top cfe_props u_cfe_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
